// ===== hw/rtl/kms_pkg.sv =====
// shared types and constants of the key matrix scanner
package kms_pkg;

  // matrix geometry
  localparam int unsigned ROWS      = 6;
  localparam int unsigned COLUMNS   = 8;
  localparam int unsigned KEY_SLOTS = 48;
  localparam int unsigned KEYS      = ROWS * COLUMNS;
  localparam int unsigned IDX_W     = $clog2(KEYS);
  localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PAUSE_W = 16;
  localparam int unsigned MASK_W  = 48;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned CFG_W   = 48;
  localparam int unsigned CFG_IDX_W = 3;

  // floor(x / 11) as (x * RECIP_11) >> RECIP_SHIFT, exact for x below 2^21
  localparam int unsigned TENFOLD_W   = PAUSE_W + 4;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_11 = 21'd1525202;

  // reset values of the registers
  localparam logic [PAUSE_W-1:0] HOLD_RST  = 16'd100;
  localparam logic [PAUSE_W-1:0] FIRST_RST = 16'd100;
  localparam logic [PAUSE_W-1:0] MIN_RST   = 16'd10;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_TIME   = 3'd0,
    REG_FIRST_PAUSE = 3'd1,
    REG_MIN_PAUSE   = 3'd2,
    REG_PRESENT     = 3'd3,
    REG_REPEAT      = 3'd4
  } cfg_reg_e;

  // event codes
  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_REPEAT  = 2'd2
  } event_kind_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } scan_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic eval;
    logic flush;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_key;
    logic stall;
    logic flush_done;
  } dp_status_t;

endpackage

// ===== hw/rtl/kms_if.sv =====
// handshake channels for scan items and key event items
interface kms_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [47:0] line_levels;

  modport source (output valid, output now_ms, output line_levels, input ready);
  modport sink   (input valid, input now_ms, input line_levels, output ready);
endinterface

interface kms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] key_row;
  logic [2:0] key_column;
  logic [1:0] event_kind;
  logic       last_event;

  modport source (output valid, output key_row, output key_column, output event_kind,
                  output last_event, input ready);
  modport sink   (input valid, input key_row, input key_column, input event_kind,
                  input last_event, output ready);
endinterface

// ===== hw/rtl/kms_ram.sv =====
// generic single write port ram with registered read
module kms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/kms_ctrl.sv =====
// scan sequencer state machine
module kms_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kms_pkg::dp_status_t status_i,
  output kms_pkg::ctrl_cmd_t  cmd_o
);
  import kms_pkg::*;

  scan_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.last_key && !status_i.stall) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (status_i.flush_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.eval    = 1'b0;
    cmd_o.flush   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_SCAN:  cmd_o.eval  = 1'b1;
      ST_FLUSH: cmd_o.flush = 1'b1;
      default:  in_ready_o  = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/kms_dp.sv =====
// scan datapath: config registers, key state, repeat timer, event queueing
module kms_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [kms_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kms_pkg::CFG_W-1:0]     cfg_data_i,
  // scan item
  input  logic [kms_pkg::TIME_W-1:0]    now_ms_i,
  input  logic [kms_pkg::MASK_W-1:0]    line_levels_i,
  // press time store
  output logic                          ram_we_o,
  output logic [kms_pkg::IDX_W-1:0]     ram_waddr_o,
  output logic [kms_pkg::TIME_W-1:0]    ram_wdata_o,
  output logic [kms_pkg::IDX_W-1:0]     ram_raddr_o,
  input  logic [kms_pkg::TIME_W-1:0]    ram_rdata_i,
  // event items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kms_pkg::POS_W-1:0]     key_row_o,
  output logic [kms_pkg::POS_W-1:0]     key_column_o,
  output logic [1:0]                    event_kind_o,
  output logic                          last_event_o,
  // control
  input  kms_pkg::ctrl_cmd_t            cmd_i,
  output kms_pkg::dp_status_t           status_o
);
  import kms_pkg::*;

  // configuration registers
  logic [PAUSE_W-1:0] hold_q, first_q, min_q;
  logic [MASK_W-1:0]  present_q, repeat_q;

  // scan item and position
  logic [TIME_W-1:0] now_q;
  logic [MASK_W-1:0] levels_q;
  logic [IDX_W-1:0]  idx_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;

  // key and repeat state
  logic [KEYS-1:0]    down_q;
  logic               armed_q;
  logic [TIME_W-1:0]  lrt_q;
  logic [PAUSE_W-1:0] pause_q;

  // pending event and output register
  logic              pend_v_q;
  logic [POS_W-1:0]  pend_row_q, pend_col_q;
  event_kind_e       pend_kind_q;
  logic              out_v_q;
  logic [POS_W-1:0]  out_row_q, out_col_q;
  event_kind_e       out_kind_q;
  logic              out_last_q;

  logic               last_key, present, pressed, down, held, repeats, fire;
  logic               do_release, do_press, do_arm, do_repeat, emit, stall, commit;
  logic               out_free, move_pend, flush_move;
  event_kind_e        emit_kind;
  logic [TIME_W-1:0]  press_age, repeat_age;
  logic [TENFOLD_W-1:0] tenfold;
  logic [TENFOLD_W+RECIP_W-1:0] quot_prod;
  logic [PAUSE_W-1:0] shrunk, next_pause;

  // key decode
  assign last_key = (row_q == ROW_W'(ROWS - 1)) && (col_q == COL_W'(COLUMNS - 1));
  assign present  = (32'(idx_q) < KEY_SLOTS) && present_q[idx_q];
  assign pressed  = !levels_q[idx_q];
  assign down     = down_q[idx_q];
  assign repeats  = repeat_q[idx_q];

  // elapsed times with wrapping differences
  assign press_age  = now_q - ram_rdata_i;
  assign repeat_age = now_q - lrt_q;
  assign held       = press_age > TIME_W'(hold_q);
  assign fire       = armed_q && (repeat_age > TIME_W'(pause_q));

  // shrunken pause: floor(pause * 10 / 11) clamped at the minimum
  assign tenfold    = (TENFOLD_W'(pause_q) << 3) + (TENFOLD_W'(pause_q) << 1);
  assign quot_prod  = (TENFOLD_W+RECIP_W)'(tenfold) * (TENFOLD_W+RECIP_W)'(RECIP_11);
  assign shrunk     = quot_prod[RECIP_SHIFT +: PAUSE_W];
  assign next_pause = (shrunk < min_q) ? min_q : shrunk;

  // per key action
  assign do_release = cmd_i.eval && present && down && held && !pressed;
  assign do_arm     = cmd_i.eval && present && down && held && pressed && repeats && !armed_q;
  assign do_repeat  = cmd_i.eval && present && down && held && pressed && repeats && fire;
  assign do_press   = cmd_i.eval && present && !down && pressed;
  assign emit       = do_release || do_repeat || do_press;
  always_comb begin
    emit_kind = EV_PRESS;
    if (do_release) emit_kind = EV_RELEASE;
    else if (do_repeat) emit_kind = EV_REPEAT;
  end

  // event queueing: the pending event learns whether it is the last one
  assign out_free   = !out_v_q || out_ready_i;
  assign stall      = emit && pend_v_q && !out_free;
  assign commit     = cmd_i.eval && !stall;
  assign flush_move = cmd_i.flush && pend_v_q && out_free;
  assign move_pend  = (emit && pend_v_q && out_free) || flush_move;

  assign status_o.last_key   = last_key;
  assign status_o.stall      = stall;
  assign status_o.flush_done = !pend_v_q || out_free;

  // press time store access, reading one key ahead
  assign ram_we_o    = do_press && commit;
  assign ram_waddr_o = idx_q;
  assign ram_wdata_o = now_q;
  always_comb begin
    ram_raddr_o = '0;
    if (cmd_i.eval) begin
      if (stall) ram_raddr_o = idx_q;
      else if (!last_key) ram_raddr_o = IDX_W'(idx_q + 1'b1);
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q    <= HOLD_RST;
      first_q   <= FIRST_RST;
      min_q     <= MIN_RST;
      present_q <= '0;
      repeat_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HOLD_TIME:   hold_q    <= cfg_data_i[PAUSE_W-1:0];
        REG_FIRST_PAUSE: first_q   <= cfg_data_i[PAUSE_W-1:0];
        REG_MIN_PAUSE:   min_q     <= cfg_data_i[PAUSE_W-1:0];
        REG_PRESENT:     present_q <= cfg_data_i[MASK_W-1:0];
        REG_REPEAT:      repeat_q  <= cfg_data_i[MASK_W-1:0];
        default:         hold_q    <= hold_q;
      endcase
    end
  end

  // captured scan item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q    <= now_ms_i;
      levels_q <= line_levels_i;
    end
  end

  // key position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.capture) begin
      idx_q <= '0;
      row_q <= '0;
      col_q <= '0;
    end else if (commit && !last_key) begin
      idx_q <= IDX_W'(idx_q + 1'b1);
      if (row_q == ROW_W'(ROWS - 1)) begin
        row_q <= '0;
        col_q <= COL_W'(col_q + 1'b1);
      end else begin
        row_q <= ROW_W'(row_q + 1'b1);
      end
    end
  end

  // key state and shared repeat timer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q  <= '0;
      armed_q <= 1'b0;
      lrt_q   <= '0;
      pause_q <= '0;
    end else if (commit) begin
      if (do_release) begin
        down_q[idx_q] <= 1'b0;
        armed_q       <= 1'b0;
      end else if (do_press) begin
        down_q[idx_q] <= 1'b1;
        armed_q       <= 1'b0;
      end else if (do_arm) begin
        armed_q <= 1'b1;
        lrt_q   <= now_q;
        pause_q <= first_q;
      end else if (do_repeat) begin
        lrt_q   <= now_q;
        pause_q <= next_pause;
      end
    end
  end

  // pending event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (emit && commit) begin
      pend_v_q <= 1'b1;
    end else if (flush_move) begin
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && commit) begin
      pend_row_q  <= POS_W'(row_q);
      pend_col_q  <= POS_W'(col_q);
      pend_kind_q <= emit_kind;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (move_pend) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_pend) begin
      out_row_q  <= pend_row_q;
      out_col_q  <= pend_col_q;
      out_kind_q <= pend_kind_q;
      out_last_q <= flush_move;
    end
  end

  assign out_valid_o  = out_v_q;
  assign key_row_o    = out_row_q;
  assign key_column_o = out_col_q;
  assign event_kind_o = out_kind_q;
  assign last_event_o = out_last_q;

endmodule

// ===== hw/rtl/key_matrix_scan_with_autorepeat.sv =====
// key matrix scanner with typematic auto-repeat, top level
// the first event item of a scan waits in the pending register until the next event or
//   the flush moves it to the output register; a new scan item is taken only in idle,
//   after the key walk, one key position per cycle reading the press time store one
//   position ahead, and the flush; an output stalled with an event waiting holds both
// reset: key state, repeat timer and queued events clear at once, registers take their
//   defaults; press times are not cleared and are only read for keys that are down
module key_matrix_scan_with_autorepeat (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kms_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kms_pkg::CFG_W-1:0]     cfg_data_i,
  kms_in_if.sink                        in_ch,
  kms_out_if.source                     out_ch
);
  import kms_pkg::*;

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [TIME_W-1:0] ram_wdata, ram_rdata;
  logic [1:0]        event_kind;

  // sequencer
  kms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  kms_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .now_ms_i      (in_ch.now_ms),
    .line_levels_i (in_ch.line_levels),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .key_row_o     (out_ch.key_row),
    .key_column_o  (out_ch.key_column),
    .event_kind_o  (event_kind),
    .last_event_o  (out_ch.last_event),
    .cmd_i         (cmd),
    .status_o      (status)
  );

  assign out_ch.event_kind = event_kind;

  // press time store
  kms_ram #(
    .WIDTH (TIME_W),
    .DEPTH (KEYS)
  ) u_press_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
